// File: sv/block_fir_filter_core_macros.svh
// Assertion macros used by the checker file of the block FIR filter.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef BLOCK_FIR_FILTER_CORE_MACROS_SVH
`define BLOCK_FIR_FILTER_CORE_MACROS_SVH

// The property holds in the same cycle as its trigger.
`define BFIR_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// The property holds in the cycle after its trigger.
`define BFIR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: sv/bfir_pkg.sv
// Shared types and constants of the block FIR filter.
// No dependencies; used by every module of the block.
package bfir_pkg;

	// Default sizes of the filter.
	localparam int TAPS_DEF       = 64;
	localparam int DATA_WIDTH_DEF = 16;

	// Fixed field widths of the interface.
	localparam int TAP_W = 6;
	localparam int CFG_W = 7;

	// Item codes.
	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_FILTER = 1'b1
	} opcode_t;

	// Control part of a beat as it travels down the cell row.
	typedef struct packed {
		logic             valid;
		opcode_t          opcode;
		logic [TAP_W-1:0] tap;
		logic             last;
	} ctl_t;

endpackage

// File: sv/block_fir_filter_core.sv
// Top level of the block FIR filter: tap count register, systolic cell row, output stage.
// Depends on bfir_pkg, bfir_cell and bfir_tail.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, opcode, tap_index,    | into block
//          | value, last                               |
//  out     | out_valid, out_stall, filtered_sample,    | out of block
//          | saturated, block_end                      |
//  cfg     | cfg_wr_en, cfg_wr_data (num_taps)         | into block
//
// One beat is accepted per clock while in_stall is low; each beat moves one
// cell per cycle unless the row is frozen, through every cell and the output register.
// Coefficient loads travel the row behind and ahead of samples in order.
// Reset clears the history and the tap count goes to TAPS; coefficients
// hold garbage until loaded.
// The whole row freezes, and in_stall rises, only while a sample result
// waits at the end of the row behind a stalled output beat.
module block_fir_filter_core #(
	parameter int TAPS       = bfir_pkg::TAPS_DEF,
	parameter int DATA_WIDTH = bfir_pkg::DATA_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       opcode,
	input  logic [bfir_pkg::TAP_W-1:0] tap_index,
	input  logic [DATA_WIDTH-1:0]      value,
	input  logic                       last,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [DATA_WIDTH-1:0]      filtered_sample,
	output logic                       saturated,
	output logic                       block_end,
	input  logic                       cfg_wr_en,
	input  logic [bfir_pkg::CFG_W-1:0] cfg_wr_data
);
	import bfir_pkg::*;

	localparam int PROD_W = 2 * DATA_WIDTH;
	localparam int SUM_W  = 2 * DATA_WIDTH + $clog2(TAPS) + 1;
	localparam int NT_W   = ($clog2(TAPS + 1) > CFG_W) ? $clog2(TAPS + 1) : CFG_W;

	logic [NT_W-1:0]       num_taps_q;
	logic                  hold;
	logic                  advance;
	ctl_t                  ctl_c  [TAPS+1];
	logic [DATA_WIDTH-1:0] xd_c   [TAPS+1];
	logic [SUM_W-1:0]      sum_c  [TAPS+1];
	logic [PROD_W-1:0]     prod_c [TAPS+1];

	// Tap count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_taps_q <= NT_W'(TAPS);
		end else if (cfg_wr_en) begin
			num_taps_q <= NT_W'(cfg_wr_data);
		end
	end

	assign advance  = !hold;
	assign in_stall = hold;

	// Head of the row: the input beat, with the rounding half LSB as seed.
	assign ctl_c[0] = '{valid: in_valid, opcode: opcode_t'(opcode),
		tap: tap_index, last: last};
	assign xd_c[0]   = value;
	assign sum_c[0]  = SUM_W'(1) << (DATA_WIDTH - 2);
	assign prod_c[0] = '0;

	// Row of tap cells.
	for (genvar k = 0; k < TAPS; k++) begin : g_cell
		bfir_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.SUM_W      (SUM_W),
			.NT_W       (NT_W),
			.IDX        (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.num_taps (num_taps_q),
			.ctl_in   (ctl_c[k]),
			.xd_in    (xd_c[k]),
			.sum_in   (sum_c[k]),
			.prod_in  (prod_c[k]),
			.ctl_s1   (ctl_c[k+1]),
			.xd_s1    (xd_c[k+1]),
			.sum_s1   (sum_c[k+1]),
			.prod_s1  (prod_c[k+1])
		);
	end

	// Rounding, saturation and output beat. The delayed sample leaving the
	// last cell is not needed.
	bfir_tail #(
		.DATA_WIDTH (DATA_WIDTH),
		.SUM_W      (SUM_W)
	) u_tail (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl_in          (ctl_c[TAPS]),
		.sum_in          (sum_c[TAPS]),
		.prod_in         (prod_c[TAPS]),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.filtered_sample (filtered_sample),
		.saturated       (saturated),
		.block_end       (block_end),
		.hold            (hold)
	);

endmodule

// File: sv/bfir_cell.sv
// One tap of the systolic FIR row: coefficient, one history sample, one multiplier.
// Depends on bfir_pkg.
module bfir_cell #(
	parameter int DATA_WIDTH = bfir_pkg::DATA_WIDTH_DEF,
	parameter int SUM_W      = 2 * bfir_pkg::DATA_WIDTH_DEF + 8,
	parameter int NT_W       = bfir_pkg::CFG_W,
	parameter int IDX        = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  logic [NT_W-1:0]           num_taps,
	input  bfir_pkg::ctl_t            ctl_in,
	input  logic [DATA_WIDTH-1:0]     xd_in,
	input  logic [SUM_W-1:0]          sum_in,
	input  logic [2*DATA_WIDTH-1:0]   prod_in,
	output bfir_pkg::ctl_t            ctl_s1,
	output logic [DATA_WIDTH-1:0]     xd_s1,
	output logic [SUM_W-1:0]          sum_s1,
	output logic [2*DATA_WIDTH-1:0]   prod_s1
);
	import bfir_pkg::*;

	localparam int PROD_W = 2 * DATA_WIDTH;

	logic                         is_sample;
	logic                         is_load_hit;
	logic                         active;
	logic signed [DATA_WIDTH-1:0] coef_q;
	logic [DATA_WIDTH-1:0]        prev_q;
	logic signed [PROD_W-1:0]     mult;
	logic [PROD_W-1:0]            prod_d;

	// Decode the beat held at this cell's input.
	assign is_sample   = ctl_in.valid && (ctl_in.opcode == OP_FILTER);
	assign is_load_hit = ctl_in.valid && (ctl_in.opcode == OP_LOAD) &&
		(int'(ctl_in.tap) == IDX);
	assign active      = (int'(num_taps) > IDX);

	// Product of this tap; taps beyond the count in use contribute nothing.
	assign mult   = $signed(coef_q) * $signed(xd_in);
	assign prod_d = active ? mult : '0;

	// Control stage and the history sample held by this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			prev_q <= '0;
		end else if (advance) begin
			ctl_s1 <= ctl_in;
			if (is_sample) begin
				prev_q <= ctl_in.last ? '0 : xd_in;
			end
		end
	end

	// Data stage: the sample moves on one place older, the sum takes the
	// product of the previous cell, and a load beat writes its coefficient.
	always_ff @(posedge clk) begin
		if (advance) begin
			xd_s1   <= is_sample ? prev_q : xd_in;
			sum_s1  <= sum_in + {{(SUM_W-PROD_W){prod_in[PROD_W-1]}}, prod_in};
			prod_s1 <= prod_d;
			if (is_load_hit) begin
				coef_q <= xd_in;
			end
		end
	end

endmodule

// File: sv/bfir_tail.sv
// Final accumulate, rounding, saturation and output register of the FIR row.
// Depends on bfir_pkg.
module bfir_tail #(
	parameter int DATA_WIDTH = bfir_pkg::DATA_WIDTH_DEF,
	parameter int SUM_W      = 2 * bfir_pkg::DATA_WIDTH_DEF + 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bfir_pkg::ctl_t          ctl_in,
	input  logic [SUM_W-1:0]        sum_in,
	input  logic [2*DATA_WIDTH-1:0] prod_in,
	input  logic                    out_stall,
	output logic                    out_valid,
	output logic [DATA_WIDTH-1:0]   filtered_sample,
	output logic                    saturated,
	output logic                    block_end,
	output logic                    hold
);
	import bfir_pkg::*;

	localparam int PROD_W = 2 * DATA_WIDTH;
	localparam int FRAC   = DATA_WIDTH - 1;
	localparam int RW     = SUM_W - FRAC;

	logic                  is_sample;
	logic                  take;
	logic                  out_valid_q;
	logic [SUM_W-1:0]      total;
	logic [RW-1:0]         rnd;
	logic                  fits;
	logic [DATA_WIDTH-1:0] sat_val;

	// The half LSB entered at the head of the row, so a floor shift rounds.
	assign total   = sum_in + {{(SUM_W-PROD_W){prod_in[PROD_W-1]}}, prod_in};
	assign rnd     = total[SUM_W-1:FRAC];
	assign fits    = (&rnd[RW-1:DATA_WIDTH-1]) || !(|rnd[RW-1:DATA_WIDTH-1]);
	assign sat_val = rnd[RW-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
		: {1'b0, {(DATA_WIDTH-1){1'b1}}};

	// Only sample beats produce a result; load beats and bubbles drop here.
	assign is_sample = ctl_in.valid && (ctl_in.opcode == OP_FILTER);
	assign take      = is_sample && (!out_valid_q || !out_stall);
	assign hold      = is_sample && out_valid_q && out_stall;
	assign out_valid = out_valid_q;

	// Output beat valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (take) begin
			filtered_sample <= fits ? rnd[DATA_WIDTH-1:0] : sat_val;
			saturated       <= !fits;
			block_end       <= ctl_in.last;
		end
	end

endmodule

// File: sv/bfir_checker.sv
// Port-level assertions of the block FIR filter, bound to its top level.
// Depends on block_fir_filter_core_macros.svh and block_fir_filter_core.
`include "block_fir_filter_core_macros.svh"

module bfir_checker #(
	parameter int DATA_WIDTH = bfir_pkg::DATA_WIDTH_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [DATA_WIDTH-1:0] filtered_sample,
	input logic                  saturated,
	input logic                  block_end
);
	localparam logic [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// A stalled output beat keeps its payload.
	`BFIR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(filtered_sample) && $stable(saturated) && $stable(block_end), "output beat changed while stalled")

	// An output beat leaves only after it was taken.
	`BFIR_ASSERT(a_out_drop, $fell(out_valid), $past(!out_stall), "output beat dropped")

	// The input side stalls only behind a full, stalled output.
	`BFIR_ASSERT(a_in_stall, in_stall, out_valid && out_stall, "input stalled without output back pressure")

	// A saturated result sits at one end of the range.
	`BFIR_ASSERT(a_sat_val, out_valid && saturated, filtered_sample == MAXV || filtered_sample == MINV, "saturated result off the range limits")

endmodule

bind block_fir_filter_core bfir_checker #(.DATA_WIDTH(DATA_WIDTH)) u_bfir_checker (.*);
